[hdl/tcce_pkg.sv]
// Shared constants and codes for the text console cursor engine.
// Depends on nothing; imported by text_console_cursor_engine.
`default_nettype none

package tcce_pkg;

  // Grid and cell geometry.
  localparam int GRID_COLUMNS = 160;
  localparam int GRID_ROWS    = 80;
  localparam int CELL_WIDTH   = 8;
  localparam int CELL_HEIGHT  = 12;

  // Digit buffer: ten four-bit digits, enough for any value below 2^31.
  localparam int DIGITS      = 10;
  localparam int DIGIT_BITS  = DIGITS * 4;
  localparam int CONV_BITS   = 31;

  // Colors and character codes.
  localparam logic [23:0] COLOR_RESET  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_BLACK  = 24'h000000;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;

  // Request codes.
  localparam logic [2:0] REQ_PUT_CHAR  = 3'd0;
  localparam logic [2:0] REQ_BACKSPACE = 3'd1;
  localparam logic [2:0] REQ_CLEAR     = 3'd2;
  localparam logic [2:0] REQ_DECIMAL   = 3'd3;
  localparam logic [2:0] REQ_HEX       = 3'd4;

  // Drawing command codes.
  localparam logic [1:0] OP_GLYPH  = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_CURSOR = 2'd3;

endpackage

`default_nettype wire

[hdl/text_console_cursor_engine.sv]
// Text console cursor engine: cursor tracking, number conversion, command output.
// Depends on tcce_pkg for geometry, character codes and request/command codes.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat:
//   req_type, char_code, number_value. Output channel (out_valid / out_stall)
//   carries one drawing command per beat; last marks the final command of a
//   request. The configuration channel (cfg_valid / cfg_ready) writes the
//   glyph color through text_color and is always ready; write it only while
//   the block is idle.
//   Put char, backspace, clear and ignored requests pass through ST_SINGLE,
//   which registers their one command before the next request is accepted.
//   A hex request loads its value straight into the digit buffer. A decimal
//   request first passes a bit-serial binary-to-BCD converter that shifts in
//   31 bits one per cycle; then a digit-serial stage drops leading zeros one
//   digit per cycle and, while the receiver does not stall, emits one digit per
//   cycle. Values of 2^31 and above take the same path as ignored requests.
//   A stalled receiver holds the command register and pauses the emitter;
//   a new request can still be accepted while the last command waits.
//   Reset homes the cursor, sets the color to white and clears out_valid.
`default_nettype none

module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] text_color,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  char_code,
  input  wire logic [31:0] number_value,
  // Command channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       draw_op,
  output logic [10:0]      pixel_x,
  output logic [9:0]       pixel_y,
  output logic [7:0]       glyph,
  output logic [23:0]      glyph_color,
  output logic [6:0]       cursor_row,
  output logic [7:0]       cursor_column,
  output logic             last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                  state;
  logic [23:0]             draw_color;
  logic [6:0]              row_position;
  logic [7:0]              column_position;
  logic [2:0]              req_kind;
  logic [7:0]              req_char;
  logic [DIGIT_BITS-1:0]   digits;
  logic [CONV_BITS-1:0]    shift_value;
  logic [4:0]              bit_count;
  logic [3:0]              digit_count;

  logic                    in_fire;
  logic                    out_free;
  logic [DIGIT_BITS-1:0]   digits_adj;
  logic [3:0]              top_digit;
  logic [7:0]              digit_char;

  // Cursor advance after a glyph, shared by characters and digits.
  logic [8:0]              col_inc;
  logic [7:0]              row_inc;
  logic [7:0]              adv_col;
  logic [6:0]              adv_row;

  // Result of the current emission.
  logic [1:0]              res_op;
  logic [7:0]              res_col;
  logic [6:0]              res_row;
  logic [7:0]              res_glyph;
  logic [23:0]             res_color;
  logic                    res_last;
  logic [6:0]              row_next;
  logic [7:0]              column_next;
  logic [15:0]             px_full;
  logic [15:0]             py_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Double-dabble correction: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      digits_adj[i*4 +: 4] = (digits[i*4 +: 4] >= 4'd5) ?
                             digits[i*4 +: 4] + 4'd3 : digits[i*4 +: 4];
    end
  end

  // Character for the most significant digit still held.
  assign top_digit  = digits[DIGIT_BITS-1 -: 4];
  assign digit_char = (top_digit < 4'd10) ? CHAR_ZERO + {4'b0, top_digit}
                                          : CHAR_UPPER_A + {4'b0, top_digit} - 8'd10;

  // Column advance with wrap into the next row, and row wrap to zero.
  always_comb begin
    col_inc = {1'b0, column_position} + 9'd1;
    row_inc = {1'b0, row_position} + 8'd1;
    if (col_inc >= 9'(GRID_COLUMNS)) begin
      adv_col = '0;
      adv_row = (row_inc >= 8'(GRID_ROWS)) ? '0 : row_inc[6:0];
    end else begin
      adv_col = col_inc[7:0];
      adv_row = row_position;
    end
  end

  // Command and new cursor for the current emission.
  always_comb begin
    res_op      = OP_CURSOR;
    res_col     = '0;
    res_row     = '0;
    res_glyph   = '0;
    res_color   = COLOR_BLACK;
    res_last    = 1'b1;
    row_next    = row_position;
    column_next = column_position;
    if (state == ST_EMIT) begin
      res_op      = OP_GLYPH;
      res_col     = column_position;
      res_row     = row_position;
      res_glyph   = digit_char;
      res_color   = draw_color;
      res_last    = (digit_count == 4'd1);
      row_next    = adv_row;
      column_next = adv_col;
    end else begin
      case (req_kind)
        REQ_PUT_CHAR: begin
          if (req_char == CHAR_NEWLINE) begin
            row_next    = (row_inc >= 8'(GRID_ROWS)) ? '0 : row_inc[6:0];
            column_next = '0;
          end else begin
            res_op      = OP_GLYPH;
            res_col     = column_position;
            res_row     = row_position;
            res_glyph   = req_char;
            res_color   = draw_color;
            row_next    = adv_row;
            column_next = adv_col;
          end
        end
        REQ_BACKSPACE: begin
          if (column_position == '0) begin
            column_next = 8'(GRID_COLUMNS - 1);
            row_next    = (row_position == '0) ? 7'(GRID_ROWS - 1) : row_position - 7'd1;
          end else begin
            column_next = column_position - 8'd1;
          end
          res_op  = OP_ERASE;
          res_col = column_next;
          res_row = row_next;
        end
        REQ_CLEAR: begin
          res_op      = OP_CLEAR;
          row_next    = '0;
          column_next = '0;
        end
        default: begin
          res_op = OP_CURSOR;
        end
      endcase
    end
  end

  // Cell position to pixel position.
  assign px_full = 16'(res_col) * 16'(CELL_WIDTH);
  assign py_full = 16'(res_row) * 16'(CELL_HEIGHT);

  // Sequencer, cursor, digit buffer and command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      draw_color      <= COLOR_RESET;
      row_position    <= '0;
      column_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        draw_color <= text_color;
      end

      // A taken beat empties the command register unless the emitter refills it.
      if (out_valid && !out_stall && !(state inside {ST_SINGLE, ST_EMIT})) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            req_kind <= req_type;
            req_char <= char_code;
            state    <= ST_SINGLE;
            if (req_type inside {REQ_DECIMAL, REQ_HEX} && !number_value[31]) begin
              if (req_type == REQ_DECIMAL) begin
                digits      <= '0;
                shift_value <= number_value[CONV_BITS-1:0];
                bit_count   <= '0;
                state       <= ST_CONV;
              end else begin
                digits      <= DIGIT_BITS'(number_value);
                digit_count <= 4'(DIGITS);
                state       <= ST_SKIP;
              end
            end
          end
        end
        ST_CONV: begin
          digits      <= {digits_adj[DIGIT_BITS-2:0], shift_value[CONV_BITS-1]};
          shift_value <= {shift_value[CONV_BITS-2:0], 1'b0};
          bit_count   <= bit_count + 5'd1;
          if (bit_count == 5'(CONV_BITS - 1)) begin
            digit_count <= 4'(DIGITS);
            state       <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop leading zeros, but always keep the last digit.
          if (top_digit == 4'd0 && digit_count > 4'd1) begin
            digits      <= {digits[DIGIT_BITS-5:0], 4'd0};
            digit_count <= digit_count - 4'd1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SINGLE, ST_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            draw_op         <= res_op;
            pixel_x         <= px_full[10:0];
            pixel_y         <= py_full[9:0];
            glyph           <= res_glyph;
            glyph_color     <= res_color;
            cursor_row      <= row_next;
            cursor_column   <= column_next;
            last            <= res_last;
            row_position    <= row_next;
            column_position <= column_next;
            digits          <= {digits[DIGIT_BITS-5:0], 4'd0};
            digit_count     <= digit_count - 4'd1;
            if (res_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The cursor never leaves the grid.
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (row_position < 7'(GRID_ROWS)) && (column_position < 8'(GRID_COLUMNS)))
    else $error("cursor outside the grid");

  // Only glyph commands can be followed by more commands of the same request.
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && draw_op != OP_GLYPH) |-> last)
    else $error("non-glyph command without last");

  // Emission starts on a nonzero digit unless only one digit is left.
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_SKIP && state == ST_EMIT) |-> (top_digit != 4'd0 || digit_count == 4'd1))
    else $error("leading zero digit emitted");

  // The BCD converter never yields a digit above nine.
  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && req_kind == REQ_DECIMAL) |-> (top_digit <= 4'd9))
    else $error("decimal digit out of range");

  // The digit counter stays within the buffer while digits are emitted.
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (digit_count != 4'd0 && digit_count <= 4'(DIGITS)))
    else $error("digit count out of range");
`endif

endmodule

`default_nettype wire
